### rtl/lif_pkg.sv
// shared types and constants for the light influence falloff pipeline
package lif_pkg;

	typedef enum logic [1:0] {
		LT_POINT   = 2'd0,
		LT_SPOT    = 2'd1,
		LT_DIR     = 2'd2,
		LT_UNKNOWN = 2'd3
	} light_kind_t;

	// register indexes, one 64-bit register every 8 bytes
	localparam logic [2:0] REG_TYPE   = 3'd0;
	localparam logic [2:0] REG_POS    = 3'd1;
	localparam logic [2:0] REG_FACING = 3'd2;
	localparam logic [2:0] REG_NEAR_R = 3'd3;
	localparam logic [2:0] REG_CUT_R  = 3'd4;
	localparam logic [2:0] REG_NEAR_H = 3'd5;
	localparam logic [2:0] REG_CUT_H  = 3'd6;

	localparam logic [15:0] INFL_FULL   = 16'd32768;
	localparam logic [31:0] PROD_HALF   = 32'd16384;
	localparam int          RAMP_QBITS  = 16;
	localparam logic [47:0] FACING_RST  = 48'd16384;

endpackage

### rtl/lif_geom.sv
// geometry pipeline: offsets, facing products, rounding and sum of squares
module lif_geom import lif_pkg::*; #(
	parameter int COORD_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  light_kind_t                   kind,
	input  logic [63:0]                   light_pos,
	input  logic [47:0]                   light_facing,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  px,
	input  logic signed [COORD_BITS-1:0]  py,
	input  logic signed [COORD_BITS-1:0]  pz,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2*COORD_BITS+3:0]       out_sumsq,
	output logic signed [COORD_BITS+6:0]  out_lin
);

	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int XW = CB + 17;
	localparam int PW = CB + 19;
	localparam int MW = CB + 7;
	localparam int NS = 7;
	localparam logic [MW-1:0] MAG_LIM = MW'(1) << CB;

	logic [NS-1:0] v_s;
	logic [NS-1:0] en;

	logic [3*CB+63:0] lpad;
	logic signed [CB-1:0] lp [3];
	logic signed [15:0] fc [3];
	logic signed [CB-1:0] pt [3];

	logic signed [DW-1:0] d_s1 [3];
	logic signed [XW-1:0] dotp_s2 [3];
	logic signed [XW-1:0] crsp_s2 [6];
	logic signed [DW-1:0] d_s2 [3];
	logic signed [PW-1:0] dot_s3;
	logic signed [PW-1:0] crs_s3 [3];
	logic signed [DW-1:0] d_s3 [3];
	logic signed [MW-1:0] lin_s4;
	logic signed [MW-1:0] crs_s4 [3];
	logic signed [DW-1:0] d_s4 [3];
	logic [CB:0] mag_s5 [3];
	logic signed [MW-1:0] lin_s5;
	logic [2*CB+1:0] sq_s6 [3];
	logic signed [MW-1:0] lin_s6;
	logic [2*CB+3:0] sum_s7;
	logic signed [MW-1:0] lin_s7;

	function automatic logic signed [MW-1:0] round_q14(input logic signed [PW-1:0] s);
		logic [PW-1:0] mag;
		logic [PW-1:0] q;
		mag = s[PW-1] ? PW'(-s) : PW'(s);
		q = (mag + PW'(8192)) >> 14;
		return s[PW-1] ? -$signed(MW'(q)) : $signed(MW'(q));
	endfunction

	assign lpad = {(3*CB)'(0), light_pos};
	assign pt[0] = px;
	assign pt[1] = py;
	assign pt[2] = pz;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lp[i] = lpad[i*CB +: CB];
			fc[i] = light_facing[i*16 +: 16];
		end
	end

	always_comb begin
		en[NS-1] = !v_s[NS-1] || out_ready;
		for (int k = NS-2; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) v_s[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		// s1: offset vector, pointing at the light for directional
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				if (kind == LT_DIR) d_s1[i] <= DW'(lp[i]) - DW'(pt[i]);
				else d_s1[i] <= DW'(pt[i]) - DW'(lp[i]);
			end
		end
		// s2: facing products
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				dotp_s2[i] <= XW'(d_s1[i]) * XW'(fc[i]);
				d_s2[i] <= d_s1[i];
			end
			crsp_s2[0] <= XW'(d_s1[1]) * XW'(fc[2]);
			crsp_s2[1] <= XW'(d_s1[2]) * XW'(fc[1]);
			crsp_s2[2] <= XW'(d_s1[2]) * XW'(fc[0]);
			crsp_s2[3] <= XW'(d_s1[0]) * XW'(fc[2]);
			crsp_s2[4] <= XW'(d_s1[0]) * XW'(fc[1]);
			crsp_s2[5] <= XW'(d_s1[1]) * XW'(fc[0]);
		end
		// s3: dot and cross sums
		if (en[2]) begin
			dot_s3 <= PW'(dotp_s2[0]) + PW'(dotp_s2[1]) + PW'(dotp_s2[2]);
			for (int i = 0; i < 3; i++) begin
				crs_s3[i] <= PW'(crsp_s2[2*i]) - PW'(crsp_s2[2*i+1]);
				d_s3[i] <= d_s2[i];
			end
		end
		// s4: round back to the coordinate scale
		if (en[3]) begin
			lin_s4 <= round_q14(dot_s3);
			for (int i = 0; i < 3; i++) begin
				crs_s4[i] <= round_q14(crs_s3[i]);
				d_s4[i] <= d_s3[i];
			end
		end
		// s5: magnitudes, clamped where the length is past every limit anyway
		if (en[4]) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [MW-1:0] c;
				logic [MW-1:0] m;
				c = (kind == LT_DIR) ? crs_s4[i] : MW'(d_s4[i]);
				m = c[MW-1] ? MW'(-c) : MW'(c);
				mag_s5[i] <= (m > MAG_LIM) ? (CB+1)'(MAG_LIM) : (CB+1)'(m);
			end
			lin_s5 <= lin_s4;
		end
		if (en[5]) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= (2*CB+2)'(mag_s5[i]) * (2*CB+2)'(mag_s5[i]);
			end
			lin_s6 <= lin_s5;
		end
		if (en[6]) begin
			sum_s7 <= (2*CB+4)'(sq_s6[0]) + (2*CB+4)'(sq_s6[1]) + (2*CB+4)'(sq_s6[2]);
			lin_s7 <= lin_s6;
		end
	end

	assign out_valid = v_s[NS-1];
	assign out_sumsq = sum_s7;
	assign out_lin = lin_s7;

endmodule

### rtl/lif_sqrt.sv
// pipelined square root, one root bit per stage, rounded to nearest
module lif_sqrt import lif_pkg::*; #(
	parameter int ROOT_W = 22,
	parameter int SIDE_W = 27
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2*ROOT_W-1:0] in_rad,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ROOT_W:0]     out_root,
	output logic [SIDE_W-1:0]   out_side
);

	localparam int NS = ROOT_W + 1;
	localparam int RW = ROOT_W + 3;

	logic [NS-1:0] v_s;
	logic [NS-1:0] en;

	logic [RW-1:0]       rem_s  [ROOT_W];
	logic [ROOT_W-1:0]   root_s [ROOT_W];
	logic [2*ROOT_W-1:0] rad_s  [ROOT_W];
	logic [SIDE_W-1:0]   side_s [ROOT_W];
	logic [ROOT_W:0]     res_sr;
	logic [SIDE_W-1:0]   side_sr;

	always_comb begin
		en[NS-1] = !v_s[NS-1] || out_ready;
		for (int k = NS-2; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) v_s[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < ROOT_W; k++) begin
			if (en[k]) begin
				logic [RW-1:0]       r;
				logic [ROOT_W-1:0]   q;
				logic [2*ROOT_W-1:0] s;
				logic [RW-1:0]       t;
				if (k == 0) begin
					r = '0;
					q = '0;
					s = in_rad;
					side_s[k] <= in_side;
				end else begin
					r = rem_s[k-1];
					q = root_s[k-1];
					s = rad_s[k-1];
					side_s[k] <= side_s[k-1];
				end
				// bring down the next two radicand bits and try a one
				r = {r[RW-3:0], s[2*ROOT_W-1 -: 2]};
				t = {1'b0, q, 2'b01};
				if (r >= t) begin
					rem_s[k] <= r - t;
					root_s[k] <= {q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= r;
					root_s[k] <= {q[ROOT_W-2:0], 1'b0};
				end
				rad_s[k] <= s << 2;
			end
		end
		// round up when the remainder is past the root
		if (en[NS-1]) begin
			res_sr <= (ROOT_W+1)'(root_s[ROOT_W-1]) +
				(ROOT_W+1)'(rem_s[ROOT_W-1] > RW'(root_s[ROOT_W-1]));
			side_sr <= side_s[ROOT_W-1];
		end
	end

	assign out_valid = v_s[NS-1];
	assign out_root = res_sr;
	assign out_side = side_sr;

endmodule

### rtl/lif_ramp.sv
// falloff decision, two pipelined ramp dividers and the final product
module lif_ramp import lif_pkg::*; #(
	parameter int COORD_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  light_kind_t                   kind,
	input  logic [COORD_BITS-1:0]         lim_near_r,
	input  logic [COORD_BITS-1:0]         lim_cut_r,
	input  logic [COORD_BITS-1:0]         lim_near_h,
	input  logic [COORD_BITS-1:0]         lim_cut_h,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [COORD_BITS+2:0]         in_len,
	input  logic signed [COORD_BITS+6:0]  in_lin,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [15:0]                   out_influence
);

	localparam int CB = COORD_BITS;
	localparam int MW = CB + 7;
	localparam int QB = RAMP_QBITS;
	localparam int NS = QB + 4;
	localparam int DIV0 = 2;

	typedef struct packed {
		logic full;
		logic zero;
		logic rf_full;
		logic hf_full;
	} ramp_flags_t;

	typedef struct packed {
		logic [CB-1:0] rem;
		logic [QB-1:0] low;
		logic [CB-1:0] den;
		logic [QB-1:0] q;
	} lane_t;

	logic [NS-1:0] v_s;
	logic [NS-1:0] en;

	ramp_flags_t flg_s1, flg_s2, flg_sm;
	ramp_flags_t flg_sd [QB];
	logic [CB-1:0] num_s1 [2];
	logic [CB-1:0] den_s1 [2];
	lane_t lane_s2 [2];
	lane_t lane_sd [QB][2];
	logic [31:0] prod_sm;
	logic [15:0] res_so;

	logic signed [MW-1:0] len_m, m1, m2;
	logic signed [MW-1:0] nr_m, cr_m, nh_m, ch_m;
	logic unk, hinf;

	function automatic lane_t div_step(input lane_t l);
		lane_t o;
		logic [CB:0] t;
		o = l;
		t = {l.rem, l.low[QB-1]};
		if (t >= {1'b0, l.den}) begin
			o.rem = CB'(t - {1'b0, l.den});
			o.q = {l.q[QB-2:0], 1'b1};
		end else begin
			o.rem = t[CB-1:0];
			o.q = {l.q[QB-2:0], 1'b0};
		end
		o.low = l.low << 1;
		return o;
	endfunction

	function automatic lane_t div_init(input logic [CB-1:0] num, input logic [CB-1:0] den);
		lane_t o;
		logic [CB+QB-1:0] n;
		// rounded quotient: (num * 2^15 + den / 2) / den
		n = (CB+QB)'({num, 15'b0}) + (CB+QB)'(den >> 1);
		o.rem = n[CB+QB-1:QB];
		o.low = n[QB-1:0];
		o.den = den;
		o.q = '0;
		return o;
	endfunction

	assign len_m = MW'(in_len);
	assign nr_m = MW'(lim_near_r);
	assign cr_m = MW'(lim_cut_r);
	assign nh_m = MW'(lim_near_h);
	assign ch_m = MW'(lim_cut_h);
	assign hinf = &lim_cut_h;

	always_comb begin
		unk = 1'b0;
		unique case (kind)
			LT_POINT: begin
				m1 = len_m;
				m2 = -MW'(1);
			end
			LT_SPOT: begin
				m1 = len_m;
				m2 = in_lin;
			end
			LT_DIR: begin
				m1 = in_lin;
				m2 = len_m;
			end
			default: begin
				m1 = '0;
				m2 = '0;
				unk = 1'b1;
			end
		endcase
	end

	always_comb begin
		en[NS-1] = !v_s[NS-1] || out_ready;
		for (int k = NS-2; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) v_s[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			flg_s1.full    <= !unk && (m1 <= nr_m) && (m2 <= nh_m);
			flg_s1.zero    <= unk || (m1 < 0) || (m1 >= cr_m) || (!hinf && (m2 >= ch_m));
			flg_s1.rf_full <= m1 <= nr_m;
			flg_s1.hf_full <= hinf || (m2 <= nh_m);
			num_s1[0] <= CB'(cr_m - m1);
			den_s1[0] <= lim_cut_r - lim_near_r;
			num_s1[1] <= CB'(ch_m - m2);
			den_s1[1] <= lim_cut_h - lim_near_h;
		end
		if (en[1]) begin
			flg_s2 <= flg_s1;
			for (int j = 0; j < 2; j++) begin
				lane_s2[j] <= div_init(num_s1[j], den_s1[j]);
			end
		end
		for (int k = 0; k < QB; k++) begin
			if (en[DIV0+k]) begin
				if (k == 0) begin
					flg_sd[k] <= flg_s2;
					for (int j = 0; j < 2; j++) lane_sd[k][j] <= div_step(lane_s2[j]);
				end else begin
					flg_sd[k] <= flg_sd[k-1];
					for (int j = 0; j < 2; j++) lane_sd[k][j] <= div_step(lane_sd[k-1][j]);
				end
			end
		end
		if (en[NS-2]) begin
			logic [15:0] rf, hf;
			rf = flg_sd[QB-1].rf_full ? INFL_FULL : lane_sd[QB-1][0].q;
			hf = flg_sd[QB-1].hf_full ? INFL_FULL : lane_sd[QB-1][1].q;
			prod_sm <= 32'(rf) * 32'(hf);
			flg_sm <= flg_sd[QB-1];
		end
		if (en[NS-1]) begin
			priority if (flg_sm.full) res_so <= INFL_FULL;
			else if (flg_sm.zero) res_so <= '0;
			else res_so <= 16'((prod_sm + PROD_HALF) >> 15);
		end
	end

	assign out_valid = v_s[NS-1];
	assign out_influence = res_so;

endmodule

### rtl/light_influence_falloff.sv
// top level: register file and the geometry, root and ramp pipelines
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata: point_x, point_y, point_z
//  m_axis    out  tvalid/tready           tdata: influence
//  apb       in   psel/penable/pwrite     7 registers, 8 bytes apart
//
// one point per cycle sustained while m_axis keeps accepting; the square root
// works one bit per stage and the ramp dividers have 16 stages.
// reset clears the valid bits and loads register defaults.
// a stall at m_axis freezes only occupied stages, bubbles keep filling.
module light_influence_falloff import lif_pkg::*; #(
	parameter int COORD_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [5:0]           paddr,
	input  logic [63:0]          pwdata,
	output logic [63:0]          prdata,
	output logic                 pready,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// point_x, point_y, point_z from bit 0, zero padded to bytes
	input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// influence
	output logic [15:0]          m_axis_tdata
);

	localparam int CB = COORD_BITS;
	localparam int MW = CB + 7;
	localparam int RT = CB + 2;

	light_kind_t   type_q;
	logic [63:0]   pos_q;
	logic [47:0]   fac_q;
	logic [CB-1:0] nr_q, cr_q, nh_q, ch_q;

	logic [2:0] reg_idx;
	logic       wr_en;

	logic               g_valid, g_ready;
	logic [2*RT-1:0]    g_sumsq;
	logic signed [MW-1:0] g_lin;
	logic               q_valid, q_ready;
	logic [RT:0]        q_root;
	logic [MW-1:0]      q_side;

	assign pready = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= LT_POINT;
			pos_q  <= '0;
			fac_q  <= FACING_RST;
			nr_q   <= CB'(64'd256);
			cr_q   <= CB'(64'd4096);
			nh_q   <= CB'(64'd256);
			ch_q   <= '1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_TYPE:   type_q <= light_kind_t'(pwdata[1:0]);
				REG_POS:    pos_q  <= pwdata;
				REG_FACING: fac_q  <= pwdata[47:0];
				REG_NEAR_R: nr_q   <= pwdata[CB-1:0];
				REG_CUT_R:  cr_q   <= pwdata[CB-1:0];
				REG_NEAR_H: nh_q   <= pwdata[CB-1:0];
				REG_CUT_H:  ch_q   <= pwdata[CB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TYPE:   prdata = 64'(type_q);
			REG_POS:    prdata = pos_q;
			REG_FACING: prdata = 64'(fac_q);
			REG_NEAR_R: prdata = 64'(nr_q);
			REG_CUT_R:  prdata = 64'(cr_q);
			REG_NEAR_H: prdata = 64'(nh_q);
			REG_CUT_H:  prdata = 64'(ch_q);
			default:    prdata = '0;
		endcase
	end

	lif_geom #(.COORD_BITS(CB)) u_geom (
		.clk         (clk),
		.arst_n      (arst_n),
		.kind        (type_q),
		.light_pos   (pos_q),
		.light_facing(fac_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.px          (s_axis_tdata[CB-1:0]),
		.py          (s_axis_tdata[2*CB-1:CB]),
		.pz          (s_axis_tdata[3*CB-1:2*CB]),
		.out_valid   (g_valid),
		.out_ready   (g_ready),
		.out_sumsq   (g_sumsq),
		.out_lin     (g_lin)
	);

	lif_sqrt #(.ROOT_W(RT), .SIDE_W(MW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (g_valid),
		.in_ready (g_ready),
		.in_rad   (g_sumsq),
		.in_side  (g_lin),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_root (q_root),
		.out_side (q_side)
	);

	lif_ramp #(.COORD_BITS(CB)) u_ramp (
		.clk          (clk),
		.arst_n       (arst_n),
		.kind         (type_q),
		.lim_near_r   (nr_q),
		.lim_cut_r    (cr_q),
		.lim_near_h   (nh_q),
		.lim_cut_h    (ch_q),
		.in_valid     (q_valid),
		.in_ready     (q_ready),
		.in_len       (q_root),
		.in_lin       ($signed(q_side)),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_influence(m_axis_tdata)
	);

endmodule
